// ===== src/hashed_timer_wheel_macros.svh =====
// Assertion helpers for the timer wheel. The checker that uses them must
// have ports named aclk and aresetn.
`ifndef HASHED_TIMER_WHEEL_MACROS_SVH
`define HASHED_TIMER_WHEEL_MACROS_SVH

// Clocking and reset qualification shared by every check.
`define HTW_CLK @(posedge aclk) disable iff (!aresetn)

// One labeled concurrent check.
`define HTW_ASSERT(label, prop) \
    label: assert property (`HTW_CLK prop) else $error("htw check failed");

`endif

// ===== src/htw_pkg.sv =====
`default_nettype none

package htw_pkg;

    localparam int NUM_BUCKETS = 256;
    localparam int BKT_W       = 8;
    localparam int MAX_TIMERS  = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int TIME_W      = 53;
    localparam int ID_W        = 32;
    localparam int RND_W       = 32;
    localparam int BLEN_W      = 20;
    localparam int DIST_W      = BKT_W + 1;
    localparam int KEY_W       = RND_W + BKT_W + 1;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_ADVANCE  = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [BKT_W-1:0] bucket;
        logic [RND_W-1:0] rounds;
    } slot_t;

endpackage

`default_nettype wire

// ===== src/htw_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module htw_div
    import htw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] dividend,
    input  wire logic [BLEN_W-1:0] divisor,
    output logic                   done,
    output logic [TIME_W-1:0]      quot,
    output logic [BLEN_W-1:0]      rem
);

    localparam int STEP_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] quot_reg, quot_next;
    logic [BLEN_W:0]   rem_reg, rem_next;
    logic [BLEN_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BLEN_W:0]   trial;
    logic [BLEN_W+1:0] diff;

    // Shift the dividend out at the top and the quotient in at the bottom.
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[BLEN_W-1:0], quot_reg[TIME_W-1]};
        diff      = {1'b0, trial} - {2'b00, dsr_reg};
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[BLEN_W+1]) begin
                rem_next  = diff[BLEN_W:0];
                quot_next = {quot_reg[TIME_W-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                quot_next = {quot_reg[TIME_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TIME_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[BLEN_W-1:0];

endmodule

`default_nettype wire

// ===== src/hashed_timer_wheel.sv =====
`default_nettype none

// Hashed timer wheel with rounds, 256 buckets and 32 timer slots.
// Input words (s_*) carry an op in s_tuser: schedule at an absolute due time,
// cancel by id, or advance to the current time. Each such op gives one reply
// word with tlast high; an advance first gives one fired word per expired
// timer in firing order, then a done word. The last word carries pending and
// the next non-empty bucket deadline. Op 3 is taken and gives nothing.
// The bucket length is to be written over the APB port only while the
// block is idle; the block itself does not enforce this. One word is in
// work at a time; s_tready is high only in the idle state. The work is
// done by a serial divider and a slot memory with one read per cycle,
// which is scanned once per pass.
// Results leave through one output register; while the receiver holds
// m_tready low the machine waits with the next result.
// After reset the wheel is empty, base time and bucket are zero, the id
// counter is zero and the bucket length is 1000.
module hashed_timer_wheel
    import htw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // time_us[52:0], timer_id[84:53]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // timer_id_res[31:0], accepted[32],
                                        // pending[33], next_due_us[86:34]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_EX    = 10'b0000001000,
        S_END   = 10'b0000010000,
        S_SELID = 10'b0000100000,
        S_FIRE  = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_ADD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    typedef enum logic [4:0] {
        P_CANCEL = 5'b00001,
        P_ADV    = 5'b00010,
        P_SEL    = 5'b00100,
        P_CMP    = 5'b01000,
        P_STAT   = 5'b10000
    } phase_t;

    localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(1000);
    localparam logic [DIST_W-1:0] BEST_INIT  = DIST_W'(NUM_BUCKETS + 1);
    localparam logic [TIME_W:0]   TIME_MAX   = {1'b0, {TIME_W{1'b1}}};

    // Slot store and per-slot firing keys.
    slot_t            slot_mem [MAX_TIMERS];
    logic [KEY_W-1:0] key_mem  [MAX_TIMERS];
    slot_t            rd_q;
    logic [KEY_W-1:0] key_q;
    logic [IDX_W-1:0] rd_addr;
    logic             slot_we;
    logic [IDX_W-1:0] slot_wa;
    slot_t            slot_wd;
    logic             key_we;
    logic [KEY_W-1:0] key_wd;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    op_t                     op_reg, op_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [ID_W-1:0]         tid_reg, tid_next;
    logic [TIME_W-1:0]       base_time_reg, base_time_next;
    logic [BKT_W-1:0]        base_bucket_reg, base_bucket_next;
    logic [ID_W-1:0]         id_cnt_reg, id_cnt_next;
    logic [BLEN_W-1:0]       blen_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        wptr_reg, wptr_next;
    logic                    found_reg, found_next;
    logic [MAX_TIMERS-1:0]   fired_reg, fired_next;
    logic [MAX_TIMERS-1:0]   emitted_reg, emitted_next;
    logic                    have_reg, have_next;
    logic [KEY_W-1:0]        selkey_reg, selkey_next;
    logic [IDX_W-1:0]        sel_reg, sel_next;
    logic [TIME_W-1:0]       steps_reg, steps_next;
    logic [DIST_W-1:0]       best_reg, best_next;
    logic [DIST_W+BLEN_W-1:0] prod_reg, prod_next;
    logic [ID_W-1:0]         res_id_reg, res_id_next;
    logic                    res_acc_reg, res_acc_next;
    logic                    res_pend_reg, res_pend_next;
    logic [TIME_W-1:0]       res_due_reg, res_due_next;

    logic                    out_valid_reg, out_valid_next;
    logic [87:0]             out_data_reg, out_data_next;
    logic [1:0]              out_user_reg, out_user_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_free;

    logic                    div_start;
    logic [TIME_W-1:0]       div_dividend;
    logic                    div_done;
    logic [TIME_W-1:0]       div_quot;
    logic [BLEN_W-1:0]       div_rem;
    logic [BLEN_W-1:0]       blen_eff;

    logic [BKT_W-1:0]        dist_raw;
    logic [DIST_W-1:0]       bkt_dist;
    logic [KEY_W-1:0]        fire_key;
    logic                    fire_now;
    logic [TIME_W-1:0]       visits;
    logic [TIME_W:0]         tib;
    logic [TIME_W:0]         due_sum;
    logic                    cfg_wr;
    logic [IDX_W-1:0]        idx_lo;

    htw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (blen_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Configuration port.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata   = (paddr == 3'd0) ? {{(32 - BLEN_W){1'b0}}, blen_reg} : 32'd0;
    assign blen_eff = (blen_reg == '0) ? BLEN_W'(1) : blen_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // The selected slot stays addressed while its fired word waits.
    assign idx_lo  = idx_reg[IDX_W-1:0];
    assign rd_addr = (state_reg == S_SELID || state_reg == S_FIRE) ? sel_reg : idx_lo;

    // Per-slot arithmetic on the word read from the store.
    always_comb begin
        dist_raw = rd_q.bucket - base_bucket_reg;
        bkt_dist = (dist_raw == '0) ? DIST_W'(NUM_BUCKETS) : {1'b0, dist_raw};
        fire_key = {1'b0, rd_q.rounds, {BKT_W{1'b0}}} + {{(KEY_W-DIST_W){1'b0}}, bkt_dist};
        fire_now = {{(TIME_W-KEY_W){1'b0}}, fire_key} <= steps_reg;
        if (steps_reg >= {{(TIME_W-DIST_W){1'b0}}, bkt_dist}) begin
            visits = ((steps_reg - {{(TIME_W-DIST_W){1'b0}}, bkt_dist}) >> BKT_W) + TIME_W'(1);
        end else begin
            visits = '0;
        end
        tib     = {1'b0, div_quot} + {{TIME_W{1'b0}}, (div_rem != '0)};
        due_sum = {1'b0, base_time_reg} + {{(TIME_W+1-DIST_W-BLEN_W){1'b0}}, prod_reg};
    end

    // Main sequencer.
    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        op_next          = op_reg;
        time_next        = time_reg;
        tid_next         = tid_reg;
        base_time_next   = base_time_reg;
        base_bucket_next = base_bucket_reg;
        id_cnt_next      = id_cnt_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        wptr_next        = wptr_reg;
        found_next       = found_reg;
        fired_next       = fired_reg;
        emitted_next     = emitted_reg;
        have_next        = have_reg;
        selkey_next      = selkey_reg;
        sel_next         = sel_reg;
        steps_next       = steps_reg;
        best_next        = best_reg;
        prod_next        = prod_reg;
        res_id_next      = res_id_reg;
        res_acc_next     = res_acc_reg;
        res_pend_next    = res_pend_reg;
        res_due_next     = res_due_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        out_last_next    = out_last_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        slot_we          = 1'b0;
        slot_wa          = idx_lo;
        slot_wd          = rd_q;
        key_we           = 1'b0;
        key_wd           = fire_key;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    time_next   = s_tdata[TIME_W-1:0];
                    tid_next    = s_tdata[TIME_W+ID_W-1:TIME_W];
                    res_id_next = '0;
                    res_acc_next = 1'b0;
                    idx_next    = '0;
                    best_next   = BEST_INIT;
                    unique case (op_t'(s_tuser))
                        OP_SCHEDULE: begin
                            if (cnt_reg < CNT_W'(MAX_TIMERS)) begin
                                div_start    = 1'b1;
                                div_dividend = (s_tdata[TIME_W-1:0] > base_time_reg) ?
                                               s_tdata[TIME_W-1:0] - base_time_reg : '0;
                                state_next   = S_DIV;
                            end else begin
                                phase_next = P_STAT;
                                state_next = S_RD;
                            end
                        end
                        OP_CANCEL: begin
                            found_next = 1'b0;
                            phase_next = P_CANCEL;
                            state_next = S_RD;
                        end
                        OP_ADVANCE: begin
                            if (s_tdata[TIME_W-1:0] >= base_time_reg) begin
                                div_start    = 1'b1;
                                div_dividend = s_tdata[TIME_W-1:0] - base_time_reg;
                                state_next   = S_DIV;
                            end else begin
                                phase_next = P_STAT;
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DIV: begin
                if (div_done) begin
                    if (op_reg == OP_SCHEDULE) begin
                        // Store the new timer at the end of the live prefix.
                        slot_we        = 1'b1;
                        slot_wa        = cnt_reg[IDX_W-1:0];
                        slot_wd.ident  = (id_cnt_reg == '1) ? ID_W'(1) : id_cnt_reg + 1'b1;
                        slot_wd.bucket = tib[BKT_W-1:0] + base_bucket_reg;
                        slot_wd.rounds = (|tib[TIME_W:RND_W+BKT_W]) ? '1 :
                                         tib[RND_W+BKT_W-1:BKT_W];
                        id_cnt_next    = slot_wd.ident;
                        res_id_next    = slot_wd.ident;
                        res_acc_next   = 1'b1;
                        cnt_next       = cnt_reg + 1'b1;
                        phase_next     = P_STAT;
                    end else begin
                        steps_next     = div_quot;
                        base_time_next = time_reg - {{(TIME_W-BLEN_W){1'b0}}, div_rem};
                        phase_next     = P_ADV;
                    end
                    idx_next   = '0;
                    state_next = S_RD;
                end
            end

            S_RD: begin
                state_next = (idx_reg >= cnt_reg) ? S_END : S_EX;
            end

            S_EX: begin
                unique case (phase_reg)
                    P_CANCEL: begin
                        if (!found_reg && rd_q.ident == tid_reg) begin
                            found_next = 1'b1;
                        end else if (found_reg) begin
                            slot_we = 1'b1;
                            slot_wa = idx_lo - 1'b1;
                        end
                    end
                    P_ADV: begin
                        key_we = 1'b1;
                        fired_next[idx_lo] = fire_now;
                        if (!fire_now) begin
                            slot_we        = 1'b1;
                            slot_wd.rounds = rd_q.rounds - visits[RND_W-1:0];
                        end
                    end
                    P_SEL: begin
                        if (fired_reg[idx_lo] && !emitted_reg[idx_lo] &&
                            (!have_reg || key_q < selkey_reg)) begin
                            have_next   = 1'b1;
                            selkey_next = key_q;
                            sel_next    = idx_lo;
                        end
                    end
                    P_CMP: begin
                        if (!fired_reg[idx_lo]) begin
                            slot_we   = 1'b1;
                            slot_wa   = wptr_reg[IDX_W-1:0];
                            wptr_next = wptr_reg + 1'b1;
                        end
                    end
                    P_STAT: begin
                        if (bkt_dist < best_reg) begin
                            best_next = bkt_dist;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 >= cnt_reg) ? S_END : S_RD;
            end

            S_END: begin
                idx_next   = '0;
                state_next = S_RD;
                unique case (phase_reg)
                    P_CANCEL: begin
                        if (found_reg) begin
                            cnt_next     = cnt_reg - 1'b1;
                            res_id_next  = tid_reg;
                            res_acc_next = 1'b1;
                        end
                        best_next  = BEST_INIT;
                        phase_next = P_STAT;
                    end
                    P_ADV: begin
                        emitted_next = '0;
                        have_next    = 1'b0;
                        phase_next   = P_SEL;
                    end
                    P_SEL: begin
                        if (have_reg) begin
                            state_next = S_SELID;
                        end else begin
                            wptr_next  = '0;
                            phase_next = P_CMP;
                        end
                    end
                    P_CMP: begin
                        cnt_next         = wptr_reg;
                        base_bucket_next = base_bucket_reg + steps_reg[BKT_W-1:0];
                        best_next        = BEST_INIT;
                        phase_next       = P_STAT;
                    end
                    P_STAT: begin
                        res_pend_next = (cnt_reg != '0);
                        res_due_next  = '0;
                        state_next    = (cnt_reg != '0) ? S_MUL : S_OUT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SELID: begin
                state_next = S_FIRE;
            end

            S_FIRE: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_data_next          = '0;
                    out_data_next[ID_W-1:0] = rd_q.ident;
                    out_user_next          = KIND_FIRED;
                    out_last_next          = 1'b0;
                    emitted_next[sel_reg]  = 1'b1;
                    have_next              = 1'b0;
                    idx_next               = '0;
                    state_next             = S_RD;
                end
            end

            S_MUL: begin
                prod_next  = {{BLEN_W{1'b0}}, best_reg} * {{DIST_W{1'b0}}, blen_eff};
                state_next = S_ADD;
            end

            S_ADD: begin
                res_due_next = (due_sum > TIME_MAX) ? TIME_MAX[TIME_W-1:0] :
                               due_sum[TIME_W-1:0];
                state_next   = S_OUT;
            end

            S_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_due_reg, res_pend_reg, res_acc_reg, res_id_reg};
                    unique case (op_reg)
                        OP_SCHEDULE: out_user_next = KIND_SCHEDULE;
                        OP_CANCEL:   out_user_next = KIND_CANCEL;
                        default:     out_user_next = KIND_DONE;
                    endcase
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot and key memories: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        rd_q <= slot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[idx_lo] <= key_wd;
        end
        key_q <= key_mem[rd_addr];
    end

    // Control state and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= P_STAT;
            base_time_reg   <= '0;
            base_bucket_reg <= '0;
            id_cnt_reg      <= '0;
            blen_reg        <= BLEN_RESET;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            base_time_reg   <= base_time_next;
            base_bucket_reg <= base_bucket_next;
            id_cnt_reg      <= id_cnt_next;
            if (cfg_wr) begin
                blen_reg <= pwdata[BLEN_W-1:0];
            end
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
        op_reg       <= op_next;
        time_reg     <= time_next;
        tid_reg      <= tid_next;
        idx_reg      <= idx_next;
        wptr_reg     <= wptr_next;
        found_reg    <= found_next;
        fired_reg    <= fired_next;
        emitted_reg  <= emitted_next;
        have_reg     <= have_next;
        selkey_reg   <= selkey_next;
        sel_reg      <= sel_next;
        steps_reg    <= steps_next;
        best_reg     <= best_next;
        prod_reg     <= prod_next;
        res_id_reg   <= res_id_next;
        res_acc_reg  <= res_acc_next;
        res_pend_reg <= res_pend_next;
        res_due_reg  <= res_due_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== src/htw_checker.sv =====
`default_nettype none

`include "hashed_timer_wheel_macros.svh"

module htw_checker
    import htw_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled word stays offered.
    `HTW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)

    // A stalled word keeps its contents.
    `HTW_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The block works on one input word at a time; the unused op is dropped at once.
    `HTW_ASSERT(a_one_in_flight, s_tvalid && s_tready && s_tuser != OP_NONE |=> !s_tready)

    // A fired word never closes the run and carries no status.
    `HTW_ASSERT(a_fired_shape, m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast && !m_tdata[32] && !m_tdata[33])

endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import htw_pkg::*;

    localparam longint unsigned TIME_MAX   = (64'd1 << 53) - 64'd1;
    localparam int              DRAIN_WAIT = 3000;
    localparam int              STALL_MAX  = 20000;

    typedef struct {
        op_t         op;
        logic [52:0] due_us;
        logic [31:0] ident;
    } request_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] ident;
        bit          taken;
        bit          busy;
        logic [52:0] deadline;
        bit          fin;
    } reply_t;

    typedef struct {
        logic [31:0]     ident;
        longint unsigned bucket;
        longint unsigned rounds;
    } wheel_entry_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    hashed_timer_wheel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the wheel.
    wheel_entry_t    wheel_slots[$];
    longint unsigned wheel_base_us  = 0;
    longint unsigned wheel_base_bkt = 0;
    logic [31:0]     next_ident     = 0;
    logic [19:0]     bucket_us_cfg  = 20'd1000;

    request_t requests[$];
    reply_t   replies_due[$];
    request_t in_flight;
    int       fail_count = 0;
    int       mismatch_count = 0;

    function automatic longint unsigned bucket_span();
        return (bucket_us_cfg == 0) ? 64'd1 : longint'(bucket_us_cfg);
    endfunction

    function automatic longint unsigned steps_to(longint unsigned b);
        longint unsigned d;
        d = (b + NUM_BUCKETS - wheel_base_bkt) % NUM_BUCKETS;
        return (d == 0) ? NUM_BUCKETS : d;
    endfunction

    // Append a closing word with pending flag and next deadline.
    function automatic void push_status(kind_t kind, logic [31:0] ident, bit taken);
        reply_t          r;
        longint unsigned best;
        longint unsigned add;
        best = NUM_BUCKETS + 1;
        r.kind = kind;
        r.ident = ident;
        r.taken = taken;
        r.busy = wheel_slots.size() != 0;
        r.deadline = '0;
        r.fin = 1'b1;
        if (r.busy) begin
            foreach (wheel_slots[i])
                if (steps_to(wheel_slots[i].bucket) < best)
                    best = steps_to(wheel_slots[i].bucket);
            add = best * bucket_span();
            r.deadline = (add > TIME_MAX - wheel_base_us) ? TIME_MAX : wheel_base_us + add;
        end
        replies_due.push_back(r);
    endfunction

    // Work out the replies of one accepted word and update the shadow wheel.
    function automatic void predict_wheel(request_t q);
        longint unsigned bl, delay, tib, steps, d, f, visits;
        wheel_entry_t    e;
        wheel_entry_t    keep[$];
        wheel_entry_t    fired[$];
        longint unsigned keys[$];
        reply_t          r;
        int              p;
        bl = bucket_span();
        case (q.op)
            OP_SCHEDULE: begin
                if (wheel_slots.size() < MAX_TIMERS) begin
                    delay = (q.due_us > wheel_base_us) ? q.due_us - wheel_base_us : 0;
                    tib = delay / bl + ((delay % bl) != 0 ? 1 : 0);
                    next_ident = next_ident + 1;
                    if (next_ident == 0)
                        next_ident = 1;
                    e.ident = next_ident;
                    e.bucket = (tib % NUM_BUCKETS + wheel_base_bkt) % NUM_BUCKETS;
                    e.rounds = (tib / NUM_BUCKETS > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF
                                                                 : tib / NUM_BUCKETS;
                    wheel_slots.push_back(e);
                    push_status(KIND_SCHEDULE, next_ident, 1'b1);
                end else begin
                    push_status(KIND_SCHEDULE, '0, 1'b0);
                end
            end
            OP_CANCEL: begin
                p = -1;
                foreach (wheel_slots[i])
                    if (p < 0 && wheel_slots[i].ident == q.ident)
                        p = i;
                if (p >= 0) begin
                    wheel_slots.delete(p);
                    push_status(KIND_CANCEL, q.ident, 1'b1);
                end else begin
                    push_status(KIND_CANCEL, '0, 1'b0);
                end
            end
            OP_ADVANCE: begin
                if (q.due_us >= wheel_base_us) begin
                    steps = (q.due_us - wheel_base_us) / bl;
                    wheel_base_us += steps * bl;
                    foreach (wheel_slots[i]) begin
                        e = wheel_slots[i];
                        d = steps_to(e.bucket);
                        f = d + e.rounds * NUM_BUCKETS;
                        if (f <= steps) begin
                            // Ties keep scheduling order.
                            p = keys.size();
                            while (p > 0 && keys[p-1] > f)
                                p--;
                            keys.insert(p, f);
                            fired.insert(p, e);
                        end else begin
                            visits = (steps >= d) ? (steps - d) / NUM_BUCKETS + 1 : 0;
                            e.rounds -= visits;
                            keep.push_back(e);
                        end
                    end
                    foreach (fired[i]) begin
                        r.kind = KIND_FIRED;
                        r.ident = fired[i].ident;
                        r.taken = 0;
                        r.busy = 0;
                        r.deadline = '0;
                        r.fin = 0;
                        replies_due.push_back(r);
                    end
                    wheel_slots = keep;
                    wheel_base_bkt = (wheel_base_bkt + steps % NUM_BUCKETS) % NUM_BUCKETS;
                end
                push_status(KIND_DONE, '0, 1'b0);
            end
            default: ;
        endcase
    endfunction

    // Sender: bursts of words separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;
    always @(posedge aclk) begin : send_proc
        request_t q;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_wheel(in_flight);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (requests.size() > 0) begin
                    q = requests.pop_front();
                    in_flight = q;
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, q.ident, q.due_us};
                    s_tuser <= q.op;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off.
    int rx_cycle  = 0;
    int rx_window = 0;
    int rx_mode   = 0;
    always @(posedge aclk) begin : recv_proc
        if (aresetn) begin
            rx_cycle++;
            if (rx_cycle >= 4000 && rx_cycle < 6500) begin
                m_tready <= 1'b0;
            end else begin
                if (rx_window == 0) begin
                    rx_window = $urandom_range(16, 96);
                    rx_mode = $urandom_range(0, 3);
                end
                rx_window--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare every result word with the oldest expected reply.
    always @(posedge aclk) begin : check_proc
        reply_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: kind %0d id %0h", m_tuser, m_tdata[31:0]);
            end else begin
                r = replies_due.pop_front();
                if (m_tuser != r.kind || m_tdata[31:0] != r.ident || m_tdata[32] != r.taken ||
                    m_tdata[33] != r.busy || m_tdata[86:34] != r.deadline ||
                    m_tlast != r.fin) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0h %0b %0b %0d %0b got %0d %0h %0b %0b %0d %0b",
                                 r.kind, r.ident, r.taken, r.busy, r.deadline, r.fin,
                                 m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33],
                                 m_tdata[86:34], m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word or APB access.
    int quiet_cycles = 0;
    always @(posedge aclk) begin : watchdog_proc
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    longint unsigned now_us;
    logic [31:0]     ident_guess;

    task automatic add_word(op_t op, longint unsigned t, logic [31:0] ident);
        request_t q;
        q.op = op;
        q.due_us = t[52:0];
        q.ident = ident;
        requests.push_back(q);
        if (op == OP_SCHEDULE)
            ident_guess++;
    endtask

    // Wait until every word is taken and every reply has come back.
    task automatic wait_idle();
        @(negedge aclk);
        while (requests.size() > 0 || s_tvalid || replies_due.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        now_us = wheel_base_us;
        ident_guess = next_ident;
    endtask

    task automatic write_bucket_len(logic [19:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {12'd0, value};
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bucket_us_cfg = value;
    endtask

    task automatic random_words(int count);
        longint unsigned bl;
        int              pick;
        bl = bucket_span();
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_word(OP_SCHEDULE, now_us + $urandom_range(0, 300) * bl, $urandom);
            else if (pick < 46)
                add_word(OP_SCHEDULE, {$urandom, $urandom} & TIME_MAX, $urandom);
            else if (pick < 52)
                add_word(OP_SCHEDULE, now_us - ((now_us > 500) ? 500 : now_us), $urandom);
            else if (pick < 70)
                add_word(OP_CANCEL, {$urandom, $urandom},
                         ($urandom_range(0, 3) == 0) ? $urandom
                                                     : ident_guess - $urandom_range(0, 8));
            else if (pick < 95) begin
                now_us += $urandom_range(0, 40) * bl + $urandom_range(0, 2) * (bl / 2);
                add_word(OP_ADVANCE, now_us, $urandom);
            end else
                add_word(OP_NONE, {$urandom, $urandom}, $urandom);
        end
    endtask

    initial begin
        now_us = 0;
        ident_guess = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: rounding, past due, rounds, misses, stale advance, unused op.
        add_word(OP_SCHEDULE, 0, 32'hFFFF_FFFF);
        add_word(OP_SCHEDULE, 1, 0);
        add_word(OP_SCHEDULE, 1000, 0);
        add_word(OP_SCHEDULE, 256000 + 5, 0);
        add_word(OP_SCHEDULE, TIME_MAX, 0);
        add_word(OP_CANCEL, TIME_MAX, 2);
        add_word(OP_CANCEL, 0, 999);
        add_word(OP_CANCEL, 0, 0);
        add_word(OP_CANCEL, 0, 32'hFFFF_FFFF);
        add_word(OP_ADVANCE, 500, 0);
        add_word(OP_ADVANCE, 3000, 0);
        add_word(OP_ADVANCE, 100, 0);
        add_word(OP_NONE, TIME_MAX, 32'hFFFF_FFFF);
        add_word(OP_ADVANCE, 600000, 0);
        add_word(OP_CANCEL, 0, 5);
        wait_idle();

        // Smallest bucket: fill the table past capacity, then fire most of it.
        write_bucket_len(20'd1);
        for (int i = 0; i < MAX_TIMERS + 2; i++)
            add_word(OP_SCHEDULE, now_us + $urandom_range(0, 600), $urandom);
        add_word(OP_ADVANCE, now_us + 400, 0);
        add_word(OP_ADVANCE, now_us + 100000, 0);
        wait_idle();
        random_words(30);
        wait_idle();

        write_bucket_len(20'd0);
        random_words(30);
        wait_idle();

        write_bucket_len(20'hFFFFF);
        random_words(30);
        wait_idle();

        write_bucket_len($urandom_range(2, 5000));
        random_words(30);
        wait_idle();

        // Largest bucket near the end of time: deadlines saturate.
        write_bucket_len(20'hFFFFF);
        add_word(OP_ADVANCE, TIME_MAX - 3000000, 0);
        add_word(OP_SCHEDULE, TIME_MAX, 7);
        add_word(OP_ADVANCE, TIME_MAX, 0);
        wait_idle();

        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/htw_pkg.sv
src/htw_div.sv
src/hashed_timer_wheel.sv
src/htw_checker.sv
tb/sv/testbench.sv
